FILE: hdl/brdp_pkg.sv
// Package with shared types, register codes and single-precision arithmetic.
package brdp_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_WIDTH    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_PER_UNIT = 1'd1;

    // Floating-point constants.
    localparam logic [31:0] FP_ZERO    = 32'h0000_0000;
    localparam logic [31:0] FP_DEF_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET   = 32'h0040_0000;

    // Input beat: four lanes of matrix and vector elements.
    typedef struct packed {
        logic [63:0] a_lanes_lo;
        logic [63:0] a_lanes_hi;
        logic [63:0] x_lanes_lo;
        logic [63:0] x_lanes_hi;
    } item_t;

    // Finished row.
    typedef struct packed {
        logic [31:0] dot_product;
        logic [15:0] row_number;
        logic        last_row;
    } result_t;

    // Per-beat control that travels beside the lane data.
    typedef struct packed {
        logic vld;
        logic last;
    } beat_ctl_t;

    // Row bookkeeping that travels beside the row sum.
    typedef struct packed {
        logic [15:0] row_number;
        logic        last_row;
    } row_meta_t;

    // Normalize, round to nearest even and pack.
    // The value is m / 2^48 * 2^(e - 127).
    function automatic logic [31:0] fp_round_pack(input logic s, input logic signed [11:0] e,
                                                  input logic [49:0] m);
        logic [5:0]         lz;
        logic [49:0]        mn;
        logic signed [11:0] en;
        logic [6:0]         amt;
        logic [49:0]        sh;
        logic               lost;
        logic [23:0]        m24;
        logic               g;
        logic               st;
        logic [7:0]         ef;
        logic [30:0]        word;
        lz = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) lz = 6'(49 - i);
        end
        mn   = m << lz;
        en   = e + 12'sd1 - $signed({6'b0, lz});
        sh   = mn;
        lost = 1'b0;
        ef   = 8'd0;
        if (en <= 12'sd0) begin
            // Subnormal result: shift right and keep what falls off as sticky.
            amt  = (en < -12'sd55) ? 7'd56 : 7'(12'sd1 - en);
            sh   = mn >> amt;
            lost = |(mn & ~({50{1'b1}} << amt));
        end else begin
            ef = 8'(en - 12'sd1);
        end
        m24  = sh[49:26];
        g    = sh[25];
        st   = (|sh[24:0]) | lost;
        word = {ef, 23'b0} + {7'b0, m24} + 31'(g & (st | m24[0]));
        if (m == 50'd0) begin
            return {s, 31'b0};
        end else if (en >= 12'sd255) begin
            return {s, 8'hFF, 23'b0};
        end else begin
            return {s, word};
        end
    endfunction

    // Single-precision multiply.
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic        a_zero;
        logic        b_zero;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [47:0] prod;
        s      = a[31] ^ b[31];
        a_nan  = (&a[30:23]) & (|a[22:0]);
        b_nan  = (&b[30:23]) & (|b[22:0]);
        a_inf  = (&a[30:23]) & ~(|a[22:0]);
        b_inf  = (&b[30:23]) & ~(|b[22:0]);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ma     = {|a[30:23], a[22:0]};
        mb     = {|b[30:23], b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        prod   = ma * mb;
        if (a_nan) begin
            return a | FP_QUIET;
        end else if (b_nan) begin
            return b | FP_QUIET;
        end else if ((a_inf & b_zero) | (b_inf & a_zero)) begin
            return FP_DEF_NAN;
        end else if (a_inf | b_inf) begin
            return {s, 8'hFF, 23'b0};
        end else begin
            return fp_round_pack(s, $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd127,
                                 {prod, 2'b0});
        end
    endfunction

    // Single-precision add.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic        swap;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [49:0] mbig;
        logic [49:0] mfull;
        logic [49:0] msml;
        logic [49:0] sum;
        a_nan = (&a[30:23]) & (|a[22:0]);
        b_nan = (&b[30:23]) & (|b[22:0]);
        a_inf = (&a[30:23]) & ~(|a[22:0]);
        b_inf = (&b[30:23]) & ~(|b[22:0]);
        swap  = b[30:0] > a[30:0];
        big   = swap ? b : a;
        sml   = swap ? a : b;
        eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d     = eb - es;
        mbig  = {1'b0, |big[30:23], big[22:0], 25'b0};
        mfull = {1'b0, |sml[30:23], sml[22:0], 25'b0};
        // Align the smaller operand; bits shifted out collapse into bit 0.
        if (d >= 8'd50) begin
            msml = {49'b0, |mfull};
        end else begin
            msml    = mfull >> d;
            msml[0] = msml[0] | (|(mfull & ~({50{1'b1}} << d)));
        end
        sum = (a[31] == b[31]) ? (mbig + msml) : (mbig - msml);
        if (a_nan) begin
            return a | FP_QUIET;
        end else if (b_nan) begin
            return b | FP_QUIET;
        end else if (a_inf & b_inf & (a[31] != b[31])) begin
            return FP_DEF_NAN;
        end else if (a_inf) begin
            return a;
        end else if (b_inf) begin
            return b;
        end else if (sum == 50'd0) begin
            return {a[31] & b[31], 31'b0};
        end else begin
            return fp_round_pack(big[31], $signed({4'b0, eb}), sum);
        end
    endfunction

endpackage

FILE: hdl/banded_row_dot_product_unit.sv
// Top level of the banded row dot product unit: control, lanes, tree and output register.
// Takes one beat per clock cycle while the output side keeps up. A row of band_width+1
// elements spans band_width/LANES+1 beats; its sum then passes the product, accumulator,
// tree and output registers. The throughput is set by the floating-point add in each lane
// accumulator, which closes on itself every beat. When the result register is full and
// stalled, the whole pipeline holds and the input is stalled.
module banded_row_dot_product_unit
    import brdp_pkg::*;
#(
    parameter int LANES = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PW = 12 + $clog2(LANES + 1);

    logic [11:0]       band_width_reg;
    logic [15:0]       rows_per_unit_reg;
    logic [11:0]       beat_reg;
    logic [15:0]       row_reg;
    logic              adv;
    logic              accept;
    logic [PW-1:0]     base;
    logic              final_beat;
    logic              row_last;
    logic [LANES-1:0]  lane_on;
    logic [31:0]       lane_a [LANES];
    logic [31:0]       lane_x [LANES];
    logic [31:0]       lane_sum [LANES];
    beat_ctl_t         ctl1_reg;
    row_meta_t         meta1_reg;
    logic              tree_in_vld_reg;
    row_meta_t         meta2_reg;
    logic              tree_vld;
    logic [31:0]       tree_sum;
    row_meta_t         tree_meta;
    logic              out_vld_reg;
    result_t           out_reg;

    // The pipeline moves unless a finished row is waiting on a stalled output.
    assign adv        = !(out_vld_reg && result_stall);
    assign item_stall = !adv;
    assign accept     = item_valid && adv;

    // Beat position within the row and lane masking.
    assign base       = PW'(beat_reg) * PW'(LANES);
    assign final_beat = (base + PW'(LANES)) > PW'(band_width_reg);
    assign row_last   = ({1'b0, row_reg} + 17'd1) >= {1'b0, rows_per_unit_reg};

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_on[k] = (base + PW'(k)) <= PW'(band_width_reg);
            lane_a[k]  = FP_ZERO;
            lane_x[k]  = FP_ZERO;
        end
        lane_a[0] = item.a_lanes_lo[31:0];
        lane_a[1] = item.a_lanes_lo[63:32];
        lane_x[0] = item.x_lanes_lo[31:0];
        lane_x[1] = item.x_lanes_lo[63:32];
        if (LANES > 2)
        begin
            lane_a[2 % LANES] = item.a_lanes_hi[31:0];
            lane_x[2 % LANES] = item.x_lanes_hi[31:0];
        end
        if (LANES > 3)
        begin
            lane_a[3 % LANES] = item.a_lanes_hi[63:32];
            lane_x[3 % LANES] = item.x_lanes_hi[63:32];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_width_reg    <= 12'd0;
            rows_per_unit_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BAND_WIDTH:    band_width_reg    <= cfg_data[11:0];
                REG_ROWS_PER_UNIT: rows_per_unit_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Beat and row counters advance on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= 12'd0;
            row_reg  <= 16'd0;
        end
        else if (accept)
        begin
            if (final_beat)
            begin
                beat_reg <= 12'd0;
                row_reg  <= row_last ? 16'd0 : (row_reg + 16'd1);
            end
            else
            begin
                beat_reg <= beat_reg + 12'd1;
            end
        end
    end

    // Control beside the product stage and the lane sum stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg        <= '0;
            tree_in_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl1_reg.vld    <= accept;
            ctl1_reg.last   <= final_beat;
            tree_in_vld_reg <= ctl1_reg.vld && ctl1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta1_reg.row_number <= row_reg;
            meta1_reg.last_row   <= row_last;
            meta2_reg            <= meta1_reg;
        end
    end

    // Lanes.
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        brdp_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .take    (accept),
            .lane_on (lane_on[k]),
            .a       (lane_a[k]),
            .x       (lane_x[k]),
            .acc_ctl (ctl1_reg),
            .sum     (lane_sum[k])
        );
    end

    // Merge of the lane sums.
    brdp_tree #(
        .N (LANES)
    ) u_tree (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (tree_in_vld_reg),
        .in_meta  (meta2_reg),
        .sums     (lane_sum),
        .out_vld  (tree_vld),
        .out_sum  (tree_sum),
        .out_meta (tree_meta)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= tree_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tree_vld)
        begin
            out_reg.dot_product <= tree_sum;
            out_reg.row_number  <= tree_meta.row_number;
            out_reg.last_row    <= tree_meta.last_row;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // A transfer of a row's final beat restarts the beat count.
    a_beat_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_beat) |=> (beat_reg == 12'd0))
        else $error("beat count did not restart after final beat");

    // A transfer of any other beat steps the beat count by one.
    a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !final_beat) |=> (beat_reg == $past(beat_reg) + 12'd1))
        else $error("beat count did not step");

    // Closing the last row of a run returns the row counter to zero.
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_beat && row_last) |=> (row_reg == 16'd0))
        else $error("row counter did not wrap after last row");

endmodule

FILE: hdl/brdp_lane.sv
// One lane: masked multiply stage and running accumulator.
module brdp_lane
    import brdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        take,
    input  logic        lane_on,
    input  logic [31:0] a,
    input  logic [31:0] x,
    input  beat_ctl_t   acc_ctl,
    output logic [31:0] sum
);

    logic [31:0] prod_reg;
    logic [31:0] acc_reg;
    logic [31:0] sum_reg;
    logic [31:0] acc_next;

    // Product of the incoming element pair; masked lanes contribute +0.0.
    always_ff @(posedge clk)
    begin
        if (adv && take)
        begin
            prod_reg <= lane_on ? fp_mul(a, x) : FP_ZERO;
        end
    end

    assign acc_next = fp_add(acc_reg, prod_reg);

    // Accumulator returns to +0.0 at the end of each row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= FP_ZERO;
        end
        else if (adv && acc_ctl.vld)
        begin
            acc_reg <= acc_ctl.last ? FP_ZERO : acc_next;
        end
    end

    // Finished lane sum handed to the reduction tree.
    always_ff @(posedge clk)
    begin
        if (adv && acc_ctl.vld && acc_ctl.last)
        begin
            sum_reg <= acc_next;
        end
    end

    assign sum = sum_reg;

endmodule

FILE: hdl/brdp_tree.sv
// Registered pairwise adder tree that merges the lane sums in lane order.
module brdp_tree
    import brdp_pkg::*;
#(
    parameter int N = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  row_meta_t   in_meta,
    input  logic [31:0] sums [N],
    output logic        out_vld,
    output logic [31:0] out_sum,
    output row_meta_t   out_meta
);

    localparam int LEVELS = $clog2(N);

    logic [31:0]       lvl  [LEVELS+1][N];
    logic              vld  [LEVELS+1];
    row_meta_t         meta [LEVELS+1];

    // Level zero is the lane sums themselves.
    for (genvar i = 0; i < N; i++)
    begin : g_in
        assign lvl[0][i] = sums[i];
    end

    assign vld[0]  = in_vld;
    assign meta[0] = in_meta;

    // Each level adds neighbors; an unpaired last entry passes through.
    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        localparam int CNT = (N + (1 << l) - 1) >> l;
        for (genvar i = 0; i < N; i++)
        begin : g_node
            if (2 * i + 1 < CNT)
            begin : g_add
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        lvl[l+1][i] <= fp_add(lvl[l][2*i], lvl[l][2*i+1]);
                    end
                end
            end
            else if (2 * i < CNT)
            begin : g_pass
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        lvl[l+1][i] <= lvl[l][2*i];
                    end
                end
            end
            else
            begin : g_zero
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        lvl[l+1][i] <= FP_ZERO;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld[l+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld[l+1] <= vld[l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                meta[l+1] <= meta[l];
            end
        end
    end

    assign out_vld  = vld[LEVELS];
    assign out_sum  = lvl[LEVELS][0];
    assign out_meta = meta[LEVELS];

endmodule
